// ===== hw/rtl/wds_pkg.sv =====
`timescale 1ns / 1ps
// wds_pkg: operation and status codes and fixed field widths for the
// weighted discrete sampler. No dependencies.
package wds_pkg;

    localparam int OP_W     = 2;
    localparam int WEIGHT_W = 32;
    localparam int NEEDLE_W = 17;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int TOTAL_W  = 9;
    localparam int FRAC_W   = 16;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEG      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

endpackage

// ===== hw/rtl/wds_prefix_mem.sv =====
`timescale 1ns / 1ps
// wds_prefix_mem: single-write, single-read synchronous memory holding the
// prefix sums. Read data registered. No dependencies.
module wds_prefix_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 39
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/wds_target_mul.sv =====
`timescale 1ns / 1ps
// wds_target_mul: two-stage needle * total product, split into two
// partial products over the halves of the total. Uses wds_pkg.
module wds_target_mul #(
    parameter int SUM_W = 39
) (
    input  logic                                  clk,
    input  logic                                  start,
    input  logic [wds_pkg::NEEDLE_W-1:0]          needle,
    input  logic [SUM_W-1:0]                      total,
    output logic [wds_pkg::NEEDLE_W+SUM_W-1:0]    target
);

    import wds_pkg::*;

    localparam int LO_W   = (SUM_W + 1) / 2;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int PROD_W = NEEDLE_W + SUM_W;

    logic [NEEDLE_W-1:0]      needle_reg;
    logic [HI_W-1:0]          hi_reg;
    logic [NEEDLE_W+LO_W-1:0] plo_reg;
    logic [NEEDLE_W+LO_W-1:0] plo_next;
    logic [NEEDLE_W+HI_W-1:0] phi;
    logic [PROD_W-1:0]        target_reg;
    logic [PROD_W-1:0]        target_next;

    assign plo_next = needle * total[LO_W-1:0];
    assign phi      = needle_reg * hi_reg;

    // stage 2: combine partial products
    assign target_next = (PROD_W'(phi) << LO_W) + PROD_W'(plo_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            needle_reg <= needle;
            hi_reg     <= total[SUM_W-1:LO_W];
            plo_reg    <= plo_next;
        end
        target_reg <= target_next;
    end

    assign target = target_reg;

endmodule

// ===== hw/rtl/weighted_discrete_sampler.sv =====
`timescale 1ns / 1ps
// weighted_discrete_sampler: top level. Weight table with running prefix sums
// and inverse-CDF pick by binary search. Uses wds_pkg, wds_prefix_mem,
// wds_target_mul.
//
//   channel   | handshake              | payload
//   ----------+------------------------+-----------------------------------
//   request   | req_valid / req_stall  | operation, weight, needle
//   response  | rsp_valid / rsp_stall  | status, picked_index, entry_total
//
// Clear, append, unknown operations and failed picks are answered straight from the idle state.
// A pick first forms the product needle * total, then runs the search steps
// (one prefix memory read each), then hands over the result.
// One request at a time; a new one is taken while the previous response sits
// in the output register, provided that register is free at the finishing edge.
// Reset clears the entry count, the total and all handshake state; the prefix
// memory is not cleared, as only entries below the count are ever read.
module weighted_discrete_sampler #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [wds_pkg::OP_W-1:0]      operation,
    input  logic signed [wds_pkg::WEIGHT_W-1:0] weight,
    input  logic [wds_pkg::NEEDLE_W-1:0]  needle,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [wds_pkg::STATUS_W-1:0]  status,
    output logic [wds_pkg::INDEX_W-1:0]   picked_index,
    output logic [wds_pkg::TOTAL_W-1:0]   entry_total
);

    import wds_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    // largest sum is below 2^31 * TABLE_ENTRIES
    localparam int SUM_W  = WEIGHT_W - 1 + IDX_W;
    localparam int PROD_W = NEEDLE_W + SUM_W;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MUL    = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_REPLY  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [IDX_W-1:0]    mid_reg, mid_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic [TOTAL_W-1:0]  etotal_reg, etotal_next;
    logic                load_rsp;

    logic                accept;
    logic                out_free;
    logic                mul_start;
    logic [PROD_W-1:0]   target;

    logic                wr_en;
    logic [SUM_W-1:0]    sum_append;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [SUM_W-1:0]    rd_data;

    logic                ge;
    logic [CNT_W-1:0]    mid_ext;
    logic [CNT_W-1:0]    lo_step, hi_step, mid_step;
    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W+INDEX_W-1:0] pick_wide;
    logic [CNT_W+TOTAL_W-1:0] count_wide;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;

    assign sum_append = total_reg + {{(SUM_W - WEIGHT_W + 1){1'b0}}, weight[WEIGHT_W-2:0]};

    // product kicks off on a pick that has something to search
    assign mul_start = accept && (operation == OP_PICK)
                       && (count_reg != '0) && (total_reg != '0);

    wds_target_mul #(
        .SUM_W (SUM_W)
    ) u_mul (
        .clk    (clk),
        .start  (mul_start),
        .needle (needle),
        .total  (total_reg),
        .target (target)
    );

    wds_prefix_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (SUM_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (sum_append),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // one search step: prefix[mid] * 2^16 >= needle * total
    assign ge       = PROD_W'({rd_data, {FRAC_W{1'b0}}}) >= target;
    assign mid_ext  = CNT_W'(mid_reg);
    assign lo_step  = ge ? lo_reg : (mid_ext + 1'b1);
    assign hi_step  = ge ? mid_ext : hi_reg;
    assign mid_step = lo_step + ((hi_step - lo_step) >> 1);
    assign last_idx = IDX_W'(count_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pick_next      = pick_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = mid_step[IDX_W-1:0];
        load_rsp       = 1'b0;
        status_next    = ST_OK;
        pick_wide      = '0;
        count_wide     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                            load_rsp   = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            load_rsp = 1'b1;
                            if (weight[WEIGHT_W-1])
                            begin
                                status_next = ST_NEG;
                            end
                            else if (count_reg >= FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                total_next = sum_append;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PICK:
                        begin
                            if (mul_start)
                            begin
                                state_next = S_MUL;
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                                load_rsp    = 1'b1;
                            end
                        end
                        default:
                        begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                // first probe lines up with the finished product
                lo_next    = '0;
                hi_next    = count_reg;
                mid_next   = IDX_W'(count_reg >> 1);
                rd_addr    = IDX_W'(count_reg >> 1);
                rd_en      = 1'b1;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step)
                begin
                    mid_next = mid_step[IDX_W-1:0];
                    rd_en    = 1'b1;
                end
                else
                begin
                    // needle past one: clamp to last entry
                    pick_next  = (lo_step >= count_reg) ? last_idx : lo_step[IDX_W-1:0];
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        pick_wide   = (state_reg == S_REPLY) ? {{INDEX_W{1'b0}}, pick_reg} : '0;
        index_next  = pick_wide[INDEX_W-1:0];
        count_wide  = {{TOTAL_W{1'b0}}, count_next};
        etotal_next = count_wide[TOTAL_W-1:0];
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        pick_reg <= pick_next;
        if (load_rsp)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            etotal_reg <= etotal_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign picked_index = index_reg;
    assign entry_total  = etotal_reg;

endmodule

// ===== tb/weighted_discrete_sampler_test.sv =====
`timescale 1ns / 1ps
// weighted_discrete_sampler_test: self-checking bench for the weighted table sampler.
// Drives requests from a directed table and then random runs (clear, append, pick, noise), and
// checks each response against a local model or a typed row. Needs wds_pkg and weighted_discrete_sampler.
module weighted_discrete_sampler_test;

    import wds_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SUM_W         = 39;          // width of a prefix sum / running total
    localparam int N_DIRECTED    = 25;
    localparam int RANDOM_TARGET = 1500;        // counted requests in the random part
    localparam int CALM_TAIL     = 150;         // last requests run with no idling
    localparam int DRAIN_CYCLES  = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 100;

    // operation 3 has no name in the package; the block ignores it
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    // one row of stimulus; typed rows carry their expected response
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [WEIGHT_W-1:0] weight;
        logic [NEEDLE_W-1:0] needle;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  picked;
        logic [TOTAL_W-1:0]  count;
    } stim_row_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  picked;
        logic [TOTAL_W-1:0]  count;
    } sample_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [OP_W-1:0]     operation = OP_CLEAR;
    logic [WEIGHT_W-1:0] weight = '0;
    logic [NEEDLE_W-1:0] needle = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  picked_index;
    logic [TOTAL_W-1:0]  entry_total;

    weighted_discrete_sampler #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .weight      (weight),
        .needle      (needle),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .picked_index(picked_index),
        .entry_total (entry_total)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the table and the expected-response store
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] shadow_prefix [TABLE_ENTRIES];
    int unsigned      shadow_count;
    logic [SUM_W-1:0] shadow_total;

    sample_result_t   pending_results[$];

    int  errors;
    int  requests_sent;     // excludes ignored operations
    int  responses_seen;
    int  status_seen [4];
    int  cycle_count;
    bit  calm;              // no idling on either side once set

    stim_row_t directed_rows [N_DIRECTED];

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Applies one accepted request to the shadow state and returns the response.
    // Pick: smallest i with prefix[i] * 2^16 >= needle * total, by binary search,
    // clamped to the last entry when nothing qualifies.
    function automatic sample_result_t predict_sample(input logic [OP_W-1:0] op,
                                                      input logic [WEIGHT_W-1:0] w,
                                                      input logic [NEEDLE_W-1:0] n);
        sample_result_t r;
        logic [63:0]    target;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        r = '0;
        if (op == OP_CLEAR)
        begin
            shadow_count = 0;
            shadow_total = '0;
        end
        else if (op == OP_APPEND)
        begin
            if (w[WEIGHT_W-1])
                r.status = ST_NEG;           // negative is checked before full
            else if (shadow_count >= TABLE_ENTRIES)
                r.status = ST_FULL;
            else
            begin
                shadow_total = shadow_total + SUM_W'(w);
                shadow_prefix[shadow_count[IDX_W-1:0]] = shadow_total;
                shadow_count = shadow_count + 1;
            end
        end
        else if (op == OP_PICK)
        begin
            if (shadow_count == 0 || shadow_total == '0)
                r.status = ST_EMPTY;
            else
            begin
                target = 64'(n) * 64'(shadow_total);
                lo = 0;
                hi = shadow_count;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if ({9'd0, shadow_prefix[mid[IDX_W-1:0]], 16'd0} >= target)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                if (lo >= shadow_count)
                    lo = shadow_count - 1;
                r.picked = lo[INDEX_W-1:0];
            end
        end
        r.count = shadow_count[TOTAL_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t model_row(input logic [OP_W-1:0] op,
                                            input logic [WEIGHT_W-1:0] w,
                                            input logic [NEEDLE_W-1:0] n);
        stim_row_t row;
        row = '0;
        row.op = op;
        row.weight = w;
        row.needle = n;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Valid is raised at an edge and held until accepted;
    // an optional gap lowers it first, so only one update per edge.
    // ------------------------------------------------------------------
    task automatic issue_request(input stim_row_t row);
        int             gap;
        sample_result_t want;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 11);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= row.op;
        weight    <= row.weight;
        needle    <= row.needle;
        // stall as seen at the edge decides acceptance
        do
            @(posedge clk);
        while (req_stall);
        want = predict_sample(row.op, row.weight, row.needle);
        if (row.typed)
            want = '{status: row.status, picked: row.picked, count: row.count};
        pending_results.push_back(want);
        if (row.op != OP_UNKNOWN)
            requests_sent++;
        if (requests_sent >= N_DIRECTED + RANDOM_TARGET - CALM_TAIL)
            calm = 1'b1;
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Weight for an append: mostly small unless big, sometimes near the top of the range,
    // now and then negative to hit the reject path.
    function automatic logic [WEIGHT_W-1:0] append_weight(input bit big);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return 32'h8000_0000 | $urandom;
        else if (sel < 15)
            return '0;
        else if (sel < 20)
            return 32'h7FFF_FFFF;
        else if (big || sel < 35)
            return $urandom & 32'h7FFF_FFFF;
        else
            return $urandom_range(1, 100);
    endfunction

    // Needle: mostly within [0, 1.0], with the ends and values past one.
    function automatic logic [NEEDLE_W-1:0] pick_needle();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        else if (sel < 20)
            return 17'd65536;
        else if (sel < 25)
            return 17'h1FFFF;
        else if (sel < 30)
            return NEEDLE_W'($urandom_range(65537, 131071));
        else
            return NEEDLE_W'($urandom_range(0, 65536));
    endfunction

    // Well-formed run: usually a clear, a batch of appends with the odd pick
    // mixed in, then a few picks. A fill run issues at least as many appends as
    // the table holds and ends them with a negative weight.
    task automatic run_sequence(input bit fill);
        int unsigned n_append;
        int unsigned n_pick;
        bit          big;
        big = ($urandom_range(0, 3) == 0);
        if (fill)
            n_append = $urandom_range(TABLE_ENTRIES, TABLE_ENTRIES + 4);
        else if ($urandom_range(0, 99) < 92)
            n_append = $urandom_range(1, 24);
        else
            n_append = $urandom_range(25, 120);
        if (fill || $urandom_range(0, 4) != 0)
            issue_request(model_row(OP_CLEAR, $urandom, NEEDLE_W'($urandom)));
        for (int i = 0; i < n_append; i++)
        begin
            issue_request(model_row(OP_APPEND, append_weight(big), NEEDLE_W'($urandom)));
            if ($urandom_range(0, 11) == 0)
                issue_request(model_row(OP_PICK, $urandom, pick_needle()));
        end
        if (fill)
            issue_request(model_row(OP_APPEND, 32'h8000_0000 | $urandom,
                                    NEEDLE_W'($urandom)));
        n_pick = $urandom_range(1, 8);
        for (int i = 0; i < n_pick; i++)
            issue_request(model_row(OP_PICK, $urandom, pick_needle()));
    endtask

    task automatic run_noise();
        int unsigned n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            issue_request(model_row(OP_W'($urandom_range(0, 3)), $urandom,
                                    NEEDLE_W'($urandom_range(0, 131071))));
    endtask

    // ------------------------------------------------------------------
    // Response side: check at the edge, then update the stall bursts
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge clk)
    begin
        sample_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            responses_seen++;
            status_seen[status]++;
            if (pending_results.size() == 0)
                flag_mismatch("response with no request pending", status, 0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", status, want.status);
                if (picked_index !== want.picked)
                    flag_mismatch("picked_index", picked_index, want.picked);
                if (entry_total !== want.count)
                    flag_mismatch("entry_total", entry_total, want.count);
            end
        end
        if (stall_left != 0)
        begin
            stall_left--;
            if (stall_left == 0)
                rsp_stall <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles, %0d responses pending",
                     cycle_count, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int seq_no;
        // op, weight, needle, typed, status, picked, count
        directed_rows = '{
            '{OP_PICK,    32'd0,          17'd0,     1'b1, ST_EMPTY, 8'd0, 9'd0}, // empty table
            '{OP_UNKNOWN, 32'hFFFF_FFFF,  17'h1FFFF, 1'b1, ST_OK,    8'd0, 9'd0}, // ignored
            '{OP_APPEND,  32'd0,          17'd0,     1'b1, ST_OK,    8'd0, 9'd1},
            '{OP_PICK,    32'd0,          17'd65536, 1'b1, ST_EMPTY, 8'd0, 9'd1}, // zero total
            '{OP_APPEND,  32'hFFFF_FFFF,  17'd0,     1'b1, ST_NEG,   8'd0, 9'd1},
            '{OP_APPEND,  32'h8000_0000,  17'd0,     1'b1, ST_NEG,   8'd0, 9'd1},
            '{OP_APPEND,  32'h7FFF_FFFF,  17'd0,     1'b1, ST_OK,    8'd0, 9'd2},
            '{OP_PICK,    32'd0,          17'd0,     1'b1, ST_OK,    8'd0, 9'd2}, // zero needle
            '{OP_PICK,    32'd0,          17'd65536, 1'b1, ST_OK,    8'd1, 9'd2},
            '{OP_PICK,    32'hFFFF_FFFF,  17'h1FFFF, 1'b1, ST_OK,    8'd1, 9'd2}, // past one
            '{OP_APPEND,  32'd1,          17'd0,     1'b1, ST_OK,    8'd0, 9'd3},
            '{OP_PICK,    32'd0,          17'd65535, 1'b0, ST_OK,    8'd0, 9'd0},
            '{OP_PICK,    32'd0,          17'd32768, 1'b0, ST_OK,    8'd0, 9'd0},
            '{OP_PICK,    32'd0,          17'd1,     1'b0, ST_OK,    8'd0, 9'd0},
            '{OP_CLEAR,   32'hFFFF_FFFF,  17'h1FFFF, 1'b1, ST_OK,    8'd0, 9'd0},
            '{OP_PICK,    32'd0,          17'd100,   1'b1, ST_EMPTY, 8'd0, 9'd0},
            '{OP_APPEND,  32'd5,          17'd0,     1'b1, ST_OK,    8'd0, 9'd1},
            '{OP_PICK,    32'd0,          17'h1FFFF, 1'b1, ST_OK,    8'd0, 9'd1}, // clamp, 1 entry
            '{OP_UNKNOWN, 32'h1234_5678,  17'd0,     1'b1, ST_OK,    8'd0, 9'd1},
            '{OP_APPEND,  32'd3,          17'd0,     1'b0, ST_OK,    8'd0, 9'd0},
            '{OP_APPEND,  32'd0,          17'd0,     1'b0, ST_OK,    8'd0, 9'd0},
            '{OP_APPEND,  32'd2,          17'd0,     1'b0, ST_OK,    8'd0, 9'd0},
            '{OP_PICK,    32'd0,          17'd40000, 1'b0, ST_OK,    8'd0, 9'd0},
            '{OP_PICK,    32'd0,          17'd65536, 1'b0, ST_OK,    8'd0, 9'd0},
            '{OP_CLEAR,   32'd0,          17'd0,     1'b1, ST_OK,    8'd0, 9'd0}
        };
        shadow_count = 0;
        shadow_total = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i]);

        // sender holds off until the block has answered everything
        req_valid <= 1'b0;
        @(posedge clk);
        wait_for_drain();

        seq_no = 0;
        while (requests_sent < N_DIRECTED + RANDOM_TARGET)
        begin
            if (seq_no == 0 || seq_no == 40)
                run_sequence(1'b1);
            else if ($urandom_range(0, 9) == 0)
                run_noise();
            else
                run_sequence(1'b0);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                wait_for_drain();
            end
            seq_no++;
        end

        req_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests in %0d runs, %0d responses: ok %0d, negative %0d, full %0d, empty %0d",
                 requests_sent, seq_no, responses_seen, status_seen[ST_OK], status_seen[ST_NEG],
                 status_seen[ST_FULL], status_seen[ST_EMPTY]);
        $display("%0d mismatches over %0d cycles", errors, cycle_count);
        if (errors == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/wds_pkg.sv
hw/rtl/wds_prefix_mem.sv
hw/rtl/wds_target_mul.sv
hw/rtl/weighted_discrete_sampler.sv
tb/weighted_discrete_sampler_test.sv
